// ===== sv/ugd_pkg.sv =====
package ugd_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned LEN_W = 3;
    localparam int unsigned ADV_W = 6;

    // configuration register indexes
    localparam logic CFG_NARROW_ADV = 1'b0;
    localparam logic CFG_WIDE_ADV   = 1'b1;

    localparam logic [ADV_W-1:0] NARROW_ADV_RST = 6'd9;
    localparam logic [ADV_W-1:0] WIDE_ADV_RST   = 6'd17;

    // fullwidth fold window and offset to ASCII
    localparam logic [CP_W-1:0] FOLD_LO   = 21'h00FF01;
    localparam logic [CP_W-1:0] FOLD_HI   = 21'h00FF5E;
    localparam logic [CP_W-1:0] FOLD_BASE = 21'h000021;

    // wide advance ranges
    localparam logic [CP_W-1:0] CJK_LO  = 21'h004E00;
    localparam logic [CP_W-1:0] CJK_HI  = 21'h009FFF;
    localparam logic [CP_W-1:0] PUNC_LO = 21'h003000;
    localparam logic [CP_W-1:0] PUNC_HI = 21'h00303F;
    localparam logic [CP_W-1:0] FW_LO   = 21'h00FF00;
    localparam logic [CP_W-1:0] FW_HI   = 21'h00FFEF;

    localparam logic [LEN_W-1:0] LEN_EMPTY = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
    } t_item;

endpackage

// ===== sv/ugd_decode.sv =====
module ugd_decode
    import ugd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_b0,
    input  logic [7:0]  i_b1,
    input  logic [7:0]  i_b2,
    input  logic [7:0]  i_b3,
    input  logic [2:0]  i_avail,
    input  logic        i_ready,
    output logic        o_ready,
    output logic        o_valid,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;

    // avail above four behaves as four in every compare below
    always_comb begin
        n_item.cp  = '0;
        n_item.len = LEN_ONE;
        if (i_avail == 3'd0) begin
            n_item.len = LEN_EMPTY;
        end else if (!i_b0[7]) begin
            n_item.cp  = {13'd0, i_b0};
            n_item.len = LEN_ONE;
        end else if (i_b0[7:5] == 3'b110 && i_avail >= 3'd2) begin
            n_item.cp  = {10'd0, i_b0[4:0], i_b1[5:0]};
            n_item.len = LEN_TWO;
        end else if (i_b0[7:4] == 4'b1110 && i_avail >= 3'd3) begin
            n_item.cp  = {5'd0, i_b0[3:0], i_b1[5:0], i_b2[5:0]};
            n_item.len = LEN_THREE;
        end else if (i_b0[7:3] == 5'b11110 && i_avail >= 3'd4) begin
            n_item.cp  = {i_b0[2:0], i_b1[5:0], i_b2[5:0], i_b3[5:0]};
            n_item.len = LEN_FOUR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/ugd_fold.sv =====
module ugd_fold
    import ugd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_ready,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;

    // only three-byte sequences in the fullwidth window are folded
    always_comb begin
        n_item = i_item;
        if (i_item.len == LEN_THREE && i_item.cp >= FOLD_LO && i_item.cp <= FOLD_HI) begin
            n_item.cp = i_item.cp - FOLD_LO + FOLD_BASE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/ugd_advance.sv =====
module ugd_advance
    import ugd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_item            i_item,
    input  logic [ADV_W-1:0] i_narrow_adv,
    input  logic [ADV_W-1:0] i_wide_adv,
    input  logic             i_ready,
    output logic             o_ready,
    output logic             o_valid,
    output t_item            o_item,
    output logic [ADV_W-1:0] o_advance
);

    logic             r_valid;
    t_item            r_item;
    logic [ADV_W-1:0] r_advance;
    logic             wide;

    assign o_ready = !r_valid || i_ready;

    assign wide = (i_item.cp >= CJK_LO  && i_item.cp <= CJK_HI)  ||
                  (i_item.cp >= PUNC_LO && i_item.cp <= PUNC_HI) ||
                  (i_item.cp >= FW_LO   && i_item.cp <= FW_HI);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item    <= i_item;
            r_advance <= wide ? i_wide_adv : i_narrow_adv;
        end
    end

    assign o_valid   = r_valid;
    assign o_item    = r_item;
    assign o_advance = r_advance;

endmodule

// ===== sv/utf8_glyph_decode.sv =====
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// input    | i_valid / o_stall    | i_lead_byte, i_second_byte, i_third_byte,
//          |                      | i_fourth_byte, i_avail_bytes
// output   | o_valid / i_stall    | o_code_point, o_byte_length, o_advance
// config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// Three register stages: decode, fullwidth fold, advance select. One transfer
// per cycle on each side unless that side is stalled. Each stage loads
// whenever it is empty or its successor takes its item, so o_stall rises
// only when all three stages hold items and i_stall is high.
// Synchronous active-low reset empties the pipe and restores the advances
// to 9 and 17.
module utf8_glyph_decode
    import ugd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_lead_byte,
    input  logic [7:0]       i_second_byte,
    input  logic [7:0]       i_third_byte,
    input  logic [7:0]       i_fourth_byte,
    input  logic [2:0]       i_avail_bytes,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CP_W-1:0]  o_code_point,
    output logic [LEN_W-1:0] o_byte_length,
    output logic [ADV_W-1:0] o_advance,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [ADV_W-1:0] i_cfg_data
);

    logic [ADV_W-1:0] r_narrow_adv;
    logic [ADV_W-1:0] r_wide_adv;

    logic  dec_ready;
    logic  dec_valid;
    t_item dec_item;
    logic  fold_ready;
    logic  fold_valid;
    t_item fold_item;
    logic  adv_ready;
    t_item adv_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow_adv <= NARROW_ADV_RST;
            r_wide_adv   <= WIDE_ADV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NARROW_ADV: r_narrow_adv <= i_cfg_data;
                CFG_WIDE_ADV:   r_wide_adv   <= i_cfg_data;
                default:        r_narrow_adv <= r_narrow_adv;
            endcase
        end
    end

    ugd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_b0    (i_lead_byte),
        .i_b1    (i_second_byte),
        .i_b2    (i_third_byte),
        .i_b3    (i_fourth_byte),
        .i_avail (i_avail_bytes),
        .i_ready (fold_ready),
        .o_ready (dec_ready),
        .o_valid (dec_valid),
        .o_item  (dec_item)
    );

    ugd_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .i_item  (dec_item),
        .i_ready (adv_ready),
        .o_ready (fold_ready),
        .o_valid (fold_valid),
        .o_item  (fold_item)
    );

    ugd_advance u_advance (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (fold_valid),
        .i_item       (fold_item),
        .i_narrow_adv (r_narrow_adv),
        .i_wide_adv   (r_wide_adv),
        .i_ready      (!i_stall),
        .o_ready      (adv_ready),
        .o_valid      (o_valid),
        .o_item       (adv_item),
        .o_advance    (o_advance)
    );

    assign o_stall       = !dec_ready;
    assign o_code_point  = adv_item.cp;
    assign o_byte_length = adv_item.len;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import ugd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_ITEMS = 270;

    // decoded glyph: code point, bytes consumed, pixel advance
    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        logic [ADV_W-1:0] adv;
    } t_glyph;

    // byte window; octet[0] is the lead byte
    typedef struct packed {
        logic [3:0][7:0] octet;
        logic [2:0]      avail;
    } t_window;

    typedef struct packed {
        t_window win;
        logic    typed;
        t_glyph  glyph;
    } t_row;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_valid       = 1'b0;
    logic             o_stall;
    logic [7:0]       i_lead_byte   = '0;
    logic [7:0]       i_second_byte = '0;
    logic [7:0]       i_third_byte  = '0;
    logic [7:0]       i_fourth_byte = '0;
    logic [2:0]       i_avail_bytes = '0;
    logic             o_valid;
    logic             i_stall       = 1'b0;
    logic [CP_W-1:0]  o_code_point;
    logic [LEN_W-1:0] o_byte_length;
    logic [ADV_W-1:0] o_advance;
    logic             i_cfg_we      = 1'b0;
    logic             i_cfg_idx     = CFG_NARROW_ADV;
    logic [ADV_W-1:0] i_cfg_data    = '0;

    // typed-in expectation travels with the payload it belongs to
    logic   drv_typed = 1'b0;
    t_glyph drv_glyph = '0;

    logic [ADV_W-1:0] narrow_adv = NARROW_ADV_RST;
    logic [ADV_W-1:0] wide_adv   = WIDE_ADV_RST;

    t_glyph due_glyphs[$];
    t_row   directed_rows[$];

    int unsigned send_pct    = 0;
    int unsigned stall_pct   = 0;
    logic        pressure_on = 1'b0;
    logic        hold        = 1'b0;

    int unsigned n_cycles   = 0;
    int unsigned n_err      = 0;
    int unsigned n_results  = 0;
    int unsigned n_items    = 0;
    int unsigned n_len[5]   = '{default: 0};
    int unsigned n_fold     = 0;
    int unsigned n_wide     = 0;
    int unsigned n_settings = 1;
    int unsigned n_holds    = 0;
    int unsigned n_backpres = 0;

    utf8_glyph_decode u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_lead_byte   (i_lead_byte),
        .i_second_byte (i_second_byte),
        .i_third_byte  (i_third_byte),
        .i_fourth_byte (i_fourth_byte),
        .i_avail_bytes (i_avail_bytes),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_point  (o_code_point),
        .o_byte_length (o_byte_length),
        .o_advance     (o_advance),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic is_wide(input logic [CP_W-1:0] cp);
        return (cp >= CJK_LO && cp <= CJK_HI) ||
               (cp >= PUNC_LO && cp <= PUNC_HI) ||
               (cp >= FW_LO && cp <= FW_HI);
    endfunction

    function automatic t_glyph decode_glyph(input t_window w);
        t_glyph     g;
        logic [2:0] n;
        logic [7:0] b0, b1, b2, b3;
        b0 = w.octet[0];
        b1 = w.octet[1];
        b2 = w.octet[2];
        b3 = w.octet[3];
        n = (w.avail > 3'd4) ? 3'd4 : w.avail;
        g.cp = '0;
        if (n == 3'd0) begin
            g.len = LEN_EMPTY;
        end else if (!b0[7]) begin
            g.cp  = {13'd0, b0};
            g.len = LEN_ONE;
        end else if (b0[7:5] == 3'b110 && n >= 3'd2) begin
            g.cp  = {10'd0, b0[4:0], b1[5:0]};
            g.len = LEN_TWO;
        end else if (b0[7:4] == 4'b1110 && n >= 3'd3) begin
            g.cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            if (g.cp >= FOLD_LO && g.cp <= FOLD_HI)
                g.cp = g.cp - FOLD_LO + FOLD_BASE;
            g.len = LEN_THREE;
        end else if (b0[7:3] == 5'b11110 && n >= 3'd4) begin
            g.cp  = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            g.len = LEN_FOUR;
        end else begin
            g.len = LEN_ONE;
        end
        g.adv = is_wide(g.cp) ? wide_adv : narrow_adv;
        return g;
    endfunction

    // mostly well-formed characters near the interesting ranges, some noise
    function automatic t_window random_window();
        t_window         w;
        logic [CP_W-1:0] cp;
        int unsigned     kind, need;
        w.octet = $urandom;
        w.avail = 3'($urandom_range(0, 7));
        kind = $urandom_range(0, 99);
        if (kind < 15)
            return w;
        if (kind >= 92) begin
            w.octet[0] = $urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                                              : 8'($urandom_range('hF8, 'hFF));
            return w;
        end
        if (kind < 30) begin
            need = 1;
            cp = CP_W'($urandom_range(0, 'h7F));
        end else if (kind < 45) begin
            need = 2;
            cp = CP_W'($urandom_range(0, 'h7FF));
        end else if (kind < 80) begin
            need = 3;
            case ($urandom_range(0, 8))
                0: cp = CJK_LO;
                1: cp = CJK_HI;
                2: cp = PUNC_LO;
                3: cp = PUNC_HI;
                4: cp = FW_LO;
                5: cp = FW_HI;
                6: cp = FOLD_LO;
                7: cp = FOLD_HI;
                default: cp = CP_W'($urandom_range(0, 'hFFFF));
            endcase
            cp = CP_W'(cp + $urandom_range(0, 6) - 3);
        end else begin
            need = 4;
            cp = CP_W'($urandom_range(0, 'h1FFFFF));
        end
        case (need)
            1: w.octet[0] = {1'b0, cp[6:0]};
            2: begin
                w.octet[0] = {3'b110, cp[10:6]};
                w.octet[1] = {2'b10, cp[5:0]};
            end
            3: begin
                w.octet[0] = {4'b1110, cp[15:12]};
                w.octet[1] = {2'b10, cp[11:6]};
                w.octet[2] = {2'b10, cp[5:0]};
            end
            default: begin
                w.octet[0] = {5'b11110, cp[20:18]};
                w.octet[1] = {2'b10, cp[17:12]};
                w.octet[2] = {2'b10, cp[11:6]};
                w.octet[3] = {2'b10, cp[5:0]};
            end
        endcase
        // continuation tags are not checked by the block
        for (int i = 1; i < 4; i++)
            if ($urandom_range(0, 3) == 0)
                w.octet[i][7:6] = 2'($urandom);
        if ($urandom_range(0, 9) == 0)
            w.avail = 3'($urandom_range(0, need - 1));
        else
            w.avail = 3'($urandom_range(need, 7));
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        n_err++;
        $display("[%0t] MISMATCH %s: got 0x%0h want 0x%0h (result %0d)",
                 $realtime, what, got, want, n_results);
    endtask

    task automatic add_row(input logic [7:0] b0, b1, b2, b3, input logic [2:0] n,
                           input logic typed, input logic [CP_W-1:0] cp,
                           input logic [LEN_W-1:0] len);
        t_row r;
        r.win.octet = {b3, b2, b1, b0};
        r.win.avail = n;
        r.typed     = typed;
        r.glyph.cp  = cp;
        r.glyph.len = len;
        r.glyph.adv = NARROW_ADV_RST;
        directed_rows.push_back(r);
    endtask

    task automatic send_window(input t_window w, input logic typed, input t_glyph g);
        while ($urandom_range(0, 99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_lead_byte   <= w.octet[0];
        i_second_byte <= w.octet[1];
        i_third_byte  <= w.octet[2];
        i_fourth_byte <= w.octet[3];
        i_avail_bytes <= w.avail;
        drv_typed     <= typed;
        drv_glyph     <= g;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (due_glyphs.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // both writes back to back, enable dropped once after the pair
    task automatic set_advances(input logic [ADV_W-1:0] narrow, input logic [ADV_W-1:0] wide);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NARROW_ADV;
        i_cfg_data <= narrow;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_WIDE_ADV;
        i_cfg_data <= wide;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        narrow_adv = narrow;
        wide_adv   = wide;
        n_settings++;
    endtask

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     n_cycles, due_glyphs.size());
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold)
            i_stall <= 1'b1;
        else
            i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // long receiver hold-offs while the sender keeps offering
    initial begin
        forever begin
            @(posedge i_clk);
            if (pressure_on) begin
                hold <= 1'b1;
                n_holds++;
                repeat ($urandom_range(60, 120)) @(posedge i_clk);
                hold <= 1'b0;
                repeat ($urandom_range(20, 50)) @(posedge i_clk);
            end
        end
    end

    logic   held = 1'b0;
    t_glyph held_glyph;

    always @(posedge i_clk) begin
        t_glyph  want, got;
        t_window w;
        if (i_rst_n) begin
            if (i_valid && o_stall)
                n_backpres++;
            if (i_valid && !o_stall) begin
                w.octet = {i_fourth_byte, i_third_byte, i_second_byte, i_lead_byte};
                w.avail = i_avail_bytes;
                want = drv_typed ? drv_glyph : decode_glyph(w);
                n_items++;
                n_len[want.len]++;
                if (want.len == LEN_THREE && want.cp < 21'h80)
                    n_fold++;
                if (is_wide(want.cp))
                    n_wide++;
                due_glyphs.push_back(want);
            end
            got.cp  = o_code_point;
            got.len = o_byte_length;
            got.adv = o_advance;
            // a stalled result must hold still
            if (held && (!o_valid || got != held_glyph))
                flag_mismatch("stalled result changed", 32'(got), 32'(held_glyph));
            held       = o_valid && i_stall;
            held_glyph = got;
            if (o_valid && !i_stall) begin
                if (due_glyphs.size() == 0) begin
                    flag_mismatch("result with nothing outstanding", 32'(got), 32'd0);
                end else begin
                    want = due_glyphs.pop_front();
                    if (got.cp != want.cp)
                        flag_mismatch("code_point", 32'(got.cp), 32'(want.cp));
                    if (got.len != want.len)
                        flag_mismatch("byte_length", 32'(got.len), 32'(want.len));
                    if (got.adv != want.adv)
                        flag_mismatch("advance", 32'(got.adv), 32'(want.adv));
                end
                n_results++;
            end
        end
    end

    initial begin
        add_row(8'h41, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1, 21'h0, LEN_EMPTY);
        add_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0, 1'b1, 21'h0, LEN_EMPTY);
        add_row(8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 1'b1, 21'h0, LEN_ONE);
        add_row(8'h7F, 8'hFF, 8'hFF, 8'hFF, 3'd1, 1'b1, 21'h7F, LEN_ONE);
        // bad lead bytes
        add_row(8'h80, 8'h80, 8'h80, 8'h80, 3'd4, 1'b1, 21'h0, LEN_ONE);
        add_row(8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd4, 1'b1, 21'h0, LEN_ONE);
        add_row(8'hF8, 8'h80, 8'h80, 8'h80, 3'd4, 1'b1, 21'h0, LEN_ONE);
        add_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 1'b1, 21'h0, LEN_ONE);
        // window too short for the lead byte
        add_row(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd1, 1'b1, 21'h0, LEN_ONE);
        add_row(8'hE4, 8'hB8, 8'h80, 8'h00, 3'd2, 1'b1, 21'h0, LEN_ONE);
        add_row(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd3, 1'b1, 21'h0, LEN_ONE);
        // range edges, fold window, four-byte max, oversize avail, overlong, surrogate
        add_row(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd2, 1'b0, '0, '0);
        add_row(8'hE4, 8'hB8, 8'h80, 8'h00, 3'd3, 1'b0, '0, '0);
        add_row(8'hE4, 8'hB7, 8'hBF, 8'h00, 3'd3, 1'b0, '0, '0);
        add_row(8'hE9, 8'hBF, 8'hBF, 8'h00, 3'd3, 1'b0, '0, '0);
        add_row(8'hE3, 8'h80, 8'h80, 8'h00, 3'd3, 1'b0, '0, '0);
        add_row(8'hE3, 8'h80, 8'hBF, 8'h00, 3'd3, 1'b0, '0, '0);
        add_row(8'hEF, 8'hBC, 8'h81, 8'h00, 3'd3, 1'b0, '0, '0);
        add_row(8'hEF, 8'hBD, 8'h9E, 8'h00, 3'd3, 1'b0, '0, '0);
        add_row(8'hEF, 8'hBC, 8'h80, 8'h00, 3'd3, 1'b0, '0, '0);
        add_row(8'hEF, 8'hBF, 8'hAF, 8'h00, 3'd3, 1'b0, '0, '0);
        add_row(8'hF7, 8'hBF, 8'hBF, 8'hBF, 3'd4, 1'b0, '0, '0);
        add_row(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd7, 1'b0, '0, '0);
        add_row(8'hC0, 8'h80, 8'h00, 8'h00, 3'd5, 1'b0, '0, '0);
        add_row(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3, 1'b0, '0, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_window(directed_rows[i].win, directed_rows[i].typed, directed_rows[i].glyph);

        for (int p = 0; p < 5; p++) begin
            drain();
            case (p)
                0: begin
                    set_advances(6'd0, 6'd63);
                    send_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    set_advances(6'd63, 6'd0);
                    send_pct = 69;
                    stall_pct <= 0;
                end
                2: begin
                    set_advances(6'($urandom), 6'($urandom));
                    send_pct = 0;
                    stall_pct <= 69;
                end
                3: begin
                    set_advances(6'd63, 6'd63);
                    send_pct = 16;
                    stall_pct <= 16;
                end
                default: begin
                    set_advances(6'($urandom), 6'($urandom));
                    send_pct = 0;
                    stall_pct <= 16;
                    pressure_on <= 1'b1;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_window(random_window(), 1'b0, '0);
        end
        pressure_on <= 1'b0;
        drain();

        $display("%0d windows: %0d empty, %0d one-byte or error, %0d/%0d/%0d of length 2/3/4",
                 n_items, n_len[0], n_len[1], n_len[2], n_len[3], n_len[4]);
        $display("%0d folds, %0d wide, %0d advance pairs, %0d hold-offs, %0d input stalls",
                 n_fold, n_wide, n_settings, n_holds, n_backpres);
        if (n_err == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== utf8_glyph_decode.f =====
sv/ugd_pkg.sv
sv/ugd_decode.sv
sv/ugd_fold.sv
sv/ugd_advance.sv
sv/utf8_glyph_decode.sv
tb/sv/testbench.sv
